// ===== hdl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the 3x3 box average
// Widths, line store depth, reciprocal constant and the command that runs
// from the front end through the queue into the datapath.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int COL_W     = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = 16;
   localparam int SAMPLE_W  = 16;

   // input beat kinds carried on req_tuser
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_FLUSH  = 1'b1;

   // configuration port
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int FW_W      = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam int MIN_DIM   = 3;
   localparam int RESET_DIM = 1024;

   // mean arithmetic: sum of nine Q8.8 values, biased to be non-negative,
   // then divided by 9 with rounding as floor((t + 4) / 9)
   localparam int RS_W        = SAMPLE_W + 2;
   localparam int SUM_W       = SAMPLE_W + 4;
   localparam int MEAN_BIAS   = 9 * 32768 + 4;
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP_NINE  = ((1 << RECIP_SHIFT) + 8) / 9;
   localparam int PROD_W      = 2 * SUM_W;
   localparam int Q_W         = PROD_W - RECIP_SHIFT;
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = SAMPLE_W'(1) << (SAMPLE_W - 1);

   // queues
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic                drain_end;  // frame's final beat, no store write or window shift
      logic                wr_en;      // sample updates the line stores
      logic                produce;    // beat yields a result
      logic                pass;       // result is the window center as is
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic                last;
      logic                pass;
      logic [SAMPLE_W-1:0] pass_val;
   } meta_type;

endpackage

// ===== hdl/bsa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_front: frame position tracking and beat classification
// Holds the frame size registers and the row and column counters, drops
// flush beats that arrive early and turns every other beat into a command.
// ----------------------------------------------------------------------------
module bsa_front import bsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   input  logic                 req_tuser,   // [0] action
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 push_valid,
   output cmd_type              push_cmd,
   input  logic                 push_ready
);

   logic [COL_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             accept;
   logic             draining;
   logic             at_end;
   logic             wrap;
   logic [COL_W-1:0] col_inc;
   logic [FW_W-1:0]  fw_raw;
   logic [ROW_W-1:0] fh_raw;
   logic             csr_hit;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & push_ready;
   assign draining   = (row_ff >= height_ff);
   assign at_end     = draining && (col_ff >= width_ff);
   assign col_inc    = col_ff + COL_W'(1);
   assign wrap       = !draining && (col_inc == width_ff);
   assign push_valid = accept && (draining || (req_tuser != ACT_FLUSH));

   always_comb begin
      push_cmd.drain_end = at_end;
      push_cmd.wr_en     = !draining;
      push_cmd.produce   = at_end || (row_ff > ROW_W'(1))
                           || ((row_ff == ROW_W'(1)) && (col_ff != '0));
      push_cmd.pass      = at_end || draining || (row_ff == ROW_W'(1))
                           || (col_ff < COL_W'(2));
      push_cmd.addr      = col_ff[ADDR_W-1:0];
      push_cmd.sample    = draining ? '0 : req_tdata;
   end

   assign fw_raw  = csr_wdata[FW_W-1:0];
   assign fh_raw  = csr_wdata[ROW_W-1:0];
   assign csr_hit = csr_wen
                    && ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_hit) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            if (32'(fw_raw) < MIN_DIM) begin
               width_in = COL_W'(MIN_DIM);
            end else if (32'(fw_raw) > MAX_WIDTH) begin
               width_in = COL_W'(MAX_WIDTH);
            end else begin
               width_in = COL_W'(fw_raw);
            end
         end else begin
            height_in = (32'(fh_raw) < MIN_DIM) ? ROW_W'(MIN_DIM) : fh_raw;
         end
         col_in = '0;
         row_in = '0;
      end else if (push_valid) begin
         if (at_end) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= COL_W'(RESET_DIM);
         height_ff <= ROW_W'(RESET_DIM);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   a_col_in_row : assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_ff)
      else $error("column counter beyond frame width");

   a_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff)
      else $error("row counter beyond drain row");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      push_valid && at_end && !csr_wen |=> (row_ff == '0) && (col_ff == '0))
      else $error("frame end did not restart the position");

endmodule

// ===== hdl/bsa_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_cmd_queue: command queue between front end and datapath
// Small circular buffer so that either side can stall on its own.
// ----------------------------------------------------------------------------
module bsa_cmd_queue import bsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;

   assign push_ready = (count_ff < CMD_CNT_W'(CMD_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (!do_push && pop) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/bsa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_back: line stores, 3x3 window and mean pipeline
// Pops commands (producing ones only while a result slot can be reserved),
// shifts the window from the two line stores, forms the rounded mean in the
// row sum, total and multiply stages and buffers results for the output channel.
// ----------------------------------------------------------------------------
module bsa_back import bsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  cmd_type             pop_cmd,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [15:0] sample_out
   output logic                rsp_tlast    // frame_last
);

   logic [SAMPLE_W-1:0] older_store_ff [MAX_WIDTH];
   logic [SAMPLE_W-1:0] newer_store_ff [MAX_WIDTH];
   logic [SAMPLE_W-1:0] older_rd_ff;
   logic [SAMPLE_W-1:0] newer_rd_ff;

   // window index is row*3 + age, row 0 oldest line, age 0 newest column
   logic [SAMPLE_W-1:0] window_ff [9];
   logic [SAMPLE_W-1:0] window_in [9];

   logic                 a_valid_ff;
   cmd_type              a_cmd_ff;
   logic                 b_valid_ff;
   meta_type             b_meta_ff, b_meta_in;
   logic                 c_valid_ff;
   meta_type             c_meta_ff;
   logic signed [RS_W-1:0] c_rowsum_ff [3];
   logic signed [RS_W-1:0] rowsum_in [3];
   logic                 d_valid_ff;
   meta_type             d_meta_ff;
   logic [SUM_W-1:0]     d_biased_ff, biased_in;
   logic signed [SUM_W-1:0] total;
   logic                 e_valid_ff;
   meta_type             e_meta_ff;
   logic [PROD_W-1:0]    e_prod_ff;

   logic [Q_W-1:0]       quot;
   logic [SAMPLE_W-1:0]  mean_val;
   logic [SAMPLE_W-1:0]  result_val;

   logic [SAMPLE_W-1:0]  out_data_ff [OUT_DEPTH];
   logic                 out_last_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [OUT_CNT_W-1:0] owed_ff, owed_in;
   logic                 out_take;
   logic                 claim;

   // a producing command reserves a buffer slot before it enters
   assign pop   = pop_valid && (!pop_cmd.produce || (owed_ff < OUT_CNT_W'(OUT_DEPTH)));
   assign claim = pop && pop_cmd.produce;

   // newer store: read first, then take the new sample
   always_ff @(posedge clock) begin
      if (pop) begin
         newer_rd_ff <= newer_store_ff[pop_cmd.addr];
         if (pop_cmd.wr_en) begin
            newer_store_ff[pop_cmd.addr] <= pop_cmd.sample;
         end
      end
   end

   // older store takes the old newer-line value in the cycle after the pop
   always_ff @(posedge clock) begin
      if (pop) begin
         older_rd_ff <= older_store_ff[pop_cmd.addr];
      end
      if (a_valid_ff && a_cmd_ff.wr_en) begin
         older_store_ff[a_cmd_ff.addr] <= newer_rd_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         window_in[k] = window_ff[k];
      end
      if (a_valid_ff && !a_cmd_ff.drain_end) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r*3+2] = window_ff[r*3+1];
            window_in[r*3+1] = window_ff[r*3];
         end
         window_in[0] = older_rd_ff;
         window_in[3] = newer_rd_ff;
         window_in[6] = a_cmd_ff.sample;
      end
      // center after the shift is the old newest middle sample, same as the final beat
      b_meta_in.last     = a_cmd_ff.drain_end;
      b_meta_in.pass     = a_cmd_ff.pass;
      b_meta_in.pass_val = window_ff[3];
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rowsum_in[r] = RS_W'($signed(window_ff[r*3])) + RS_W'($signed(window_ff[r*3+1]))
                        + RS_W'($signed(window_ff[r*3+2]));
      end
      total     = SUM_W'(c_rowsum_ff[0]) + SUM_W'(c_rowsum_ff[1]) + SUM_W'(c_rowsum_ff[2]);
      biased_in = SUM_W'(total) + SUM_W'(MEAN_BIAS);
   end

   always_comb begin
      quot       = e_prod_ff[RECIP_SHIFT +: Q_W];
      mean_val   = quot[Q_W-1] ? '1 : quot[SAMPLE_W-1:0];
      result_val = e_meta_ff.pass ? e_meta_ff.pass_val : (mean_val ^ SIGN_FLIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= window_in[k];
         end
         a_valid_ff <= pop;
         b_valid_ff <= a_valid_ff && a_cmd_ff.produce;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_cmd_ff  <= pop_cmd;
      b_meta_ff <= b_meta_in;
      c_meta_ff <= b_meta_ff;
      for (int r = 0; r < 3; r++) begin
         c_rowsum_ff[r] <= rowsum_in[r];
      end
      d_meta_ff   <= c_meta_ff;
      d_biased_ff <= biased_in;
      e_meta_ff   <= d_meta_ff;
      e_prod_ff   <= PROD_W'(d_biased_ff) * PROD_W'(RECIP_NINE);
   end

   // result buffer
   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tdata  = out_data_ff[out_rd_ff];
   assign rsp_tlast  = out_last_ff[out_rd_ff];
   assign out_take   = rsp_tvalid && rsp_tready;

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      owed_in    = owed_ff;
      if (e_valid_ff) begin
         out_wr_in = (out_wr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_ff + OUT_PTR_W'(1);
      end
      if (out_take) begin
         out_rd_in = (out_rd_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_ff + OUT_PTR_W'(1);
      end
      if (e_valid_ff && !out_take) begin
         out_cnt_in = out_cnt_ff + OUT_CNT_W'(1);
      end else if (!e_valid_ff && out_take) begin
         out_cnt_in = out_cnt_ff - OUT_CNT_W'(1);
      end
      if (claim && !out_take) begin
         owed_in = owed_ff + OUT_CNT_W'(1);
      end else if (!claim && out_take) begin
         owed_in = owed_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
         owed_ff    <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
         owed_ff    <= owed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_valid_ff) begin
         out_data_ff[out_wr_ff] <= result_val;
         out_last_ff[out_wr_ff] <= e_meta_ff.last;
      end
   end

   a_owed_bound : assert property (@(posedge clock) disable iff (reset)
      owed_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("more results in flight than buffer slots");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (out_cnt_ff < OUT_CNT_W'(OUT_DEPTH)) || out_take)
      else $error("result buffer overflow");

   a_buffered_covered : assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= owed_ff)
      else $error("buffered results exceed reserved slots");

endmodule

// ===== hdl/box_stencil_3x3_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_stencil_3x3_average: 3x3 mean filter over a raster-order frame
// Front end, command queue and line-store datapath of the box average.
// ----------------------------------------------------------------------------
// Takes one beat per clock when the output keeps up: each beat is a sample or
// a flush step, and at most one filtered sample leaves per beat. Results lag
// the input stream by frame_width+1 positions, so a frame needs frame_width+1
// flush beats after its last sample; the last of them carries tlast. Edge
// rows and columns pass through, interior samples get the rounded 9-point
// mean. Internally an accepted beat passes the command queue, the line store
// read, the window shift, the row sums, the total and the reciprocal multiply;
// rounding follows as the result enters the result buffer. The two
// line stores are single memories of 1024 words each (read and written once
// per cycle) and are not cleared after reset; a frame never uses a word it
// has not written. Frame size writes restart the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module box_stencil_3x3_average import bsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   input  logic                 req_tuser,   // [0] action
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   output logic                 rsp_tlast,   // frame_last
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   bsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   bsa_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   bsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/box_stencil_3x3_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_stencil_3x3_average_tb: self-checking bench for the 3x3 box average
// Streams raster frames of many sizes into the filter and predicts every
// filtered sample and the frame-closing flag with its own line stores and
// window. It covers edge values, size clamps, restarts on size writes,
// dropped and surplus flush beats, long output backpressure and random idling.
// ----------------------------------------------------------------------------
module box_stencil_3x3_average_tb;
   import bsa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_BEATS  = 130;
   localparam int WIDE_BEATS    = 40;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } stencil_out_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata  = '0;   // [15:0] sample_in
   logic                 req_tuser  = 1'b0; // [0] action
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;         // [15:0] sample_out
   logic                 rsp_tlast;
   logic                 csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   logic        rsp_hold       = 1'b0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned beats_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned csr_writes     = 0;
   int unsigned mismatch_count = 0;

   stencil_out_type pending_out[$];
   stencil_out_type oldest_due;

   // predictor state: line stores, window and frame position
   logic [SAMPLE_W-1:0] older_row [MAX_WIDTH];
   logic [SAMPLE_W-1:0] newer_row [MAX_WIDTH];
   logic [SAMPLE_W-1:0] win [9];   // row*3 + age, row 0 oldest line, age 0 newest
   int unsigned         row_pos;
   int unsigned         col_pos;
   logic [FW_W-1:0]     width_reg;
   logic [ROW_W-1:0]    height_reg;

   // effective frame size the stimulus works with
   int unsigned frame_w;
   int unsigned frame_h;

   box_stencil_3x3_average uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_out.size() == 0) begin
            report_mismatch($sformatf("unexpected beat data 0x%04h last %0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            oldest_due = pending_out.pop_front();
            if (rsp_tdata !== oldest_due.value) begin
               report_mismatch($sformatf("sample_out expected 0x%04h got 0x%04h",
                                         oldest_due.value, rsp_tdata));
            end
            if (rsp_tlast !== oldest_due.last) begin
               report_mismatch($sformatf("frame_last expected %0b got %0b",
                                         oldest_due.last, rsp_tlast));
            end
         end
      end
   end

   function automatic int unsigned frame_cols();
      int unsigned w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned frame_rows();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
   endfunction

   // rounded mean of the nine window samples, via a bias that keeps it positive
   function automatic logic [SAMPLE_W-1:0] nine_point_mean();
      int acc;
      acc = 0;
      for (int k = 0; k < 9; k++) acc += $signed(win[k]);
      acc = (acc + 9 * 32768 + 4) / 9 - 32768;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return SAMPLE_W'(acc);
   endfunction

   // advances the frame by one beat; returns 0 when the beat is dropped
   function automatic bit step_stencil(input logic act, input logic [SAMPLE_W-1:0] smp);
      int unsigned         w, h, r, c, slot, judge_row, judge_col;
      bit                  draining, emits;
      logic [SAMPLE_W-1:0] x;
      stencil_out_type     due;
      w = frame_cols();
      h = frame_rows();
      r = row_pos;
      c = col_pos;
      draining = (r >= h);
      if (!draining && act == ACT_FLUSH) return 1'b0;
      x = draining ? '0 : smp;
      if (draining && c >= w) begin
         // closing beat: newest column of the middle window row
         due.value = win[3];
         due.last  = 1'b1;
         pending_out.push_back(due);
         row_pos = 0;
         col_pos = 0;
         return 1'b1;
      end
      slot = c % MAX_WIDTH;
      for (int k = 0; k < 3; k++) begin
         win[k*3+2] = win[k*3+1];
         win[k*3+1] = win[k*3];
      end
      win[0] = older_row[slot];
      win[3] = newer_row[slot];
      win[6] = x;
      if (!draining) begin
         older_row[slot] = newer_row[slot];
         newer_row[slot] = x;
      end
      emits = (r > 1) || (r == 1 && c >= 1);
      c++;
      if (!draining && c == w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
      if (emits) begin
         if (c == 0 && !draining) begin
            judge_row = r - 1;
            judge_col = w - 1;
         end else begin
            judge_row = r;
            judge_col = c - 1;
         end
         // border rows and border columns keep the center sample
         if (judge_row == 1 || judge_row == h || judge_col < 2) begin
            due.value = win[4];
         end else begin
            due.value = nine_point_mean();
         end
         due.last = 1'b0;
         pending_out.push_back(due);
      end
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return SAMPLE_W'($urandom_range(0, 511) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_beat(input logic act, input logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (step_stencil(act, smp)) beats_sent++;
   endtask

   // waits until every result is out and rows that give none have left the pipe
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      settle_block();
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      csr_writes++;
      if (idx == CSR_FRAME_WIDTH) begin
         width_reg = val[FW_W-1:0];
         row_pos   = 0;
         col_pos   = 0;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         height_reg = val;
         row_pos    = 0;
         col_pos    = 0;
      end
   endtask

   task automatic configure_frame(input logic [CSR_W-1:0] w_val, input logic [CSR_W-1:0] h_val);
      write_reg(CSR_FRAME_WIDTH, w_val);
      write_reg(CSR_FRAME_HEIGHT, h_val);
      frame_w = frame_cols();
      frame_h = frame_rows();
   endtask

   // samples with a sprinkle of dropped flush beats, then optionally the drain
   task automatic send_frame(input int unsigned count, input bit with_drain);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < 4) send_beat(ACT_FLUSH, SAMPLE_W'($urandom));
         send_beat(ACT_SAMPLE, pick_sample());
      end
      if (with_drain) begin
         for (int unsigned i = 0; i <= frame_w; i++) begin
            send_beat(($urandom_range(99) < 80) ? ACT_FLUSH : ACT_SAMPLE, pick_sample());
         end
      end
   endtask

   task automatic test_default_size();
      // reset size is 1024 x 1024; a few row-0 samples, then a size write restarts
      for (int i = 0; i < 4; i++) send_beat(ACT_SAMPLE, pick_sample());
   endtask

   task automatic test_edge_values();
      logic [SAMPLE_W-1:0] mix [9];
      mix = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF,
              16'h8000, 16'h0100, 16'hFF00, 16'h7FFF};
      configure_frame(16'hF803, 16'd3);   // upper width bits are unused
      for (int i = 0; i < 9; i++) begin
         send_beat(ACT_SAMPLE, mix[i]);
         if (i == 4) send_beat(ACT_FLUSH, 16'hA5A5);   // dropped mid frame
      end
      // samples during the drain only step it
      send_beat(ACT_FLUSH, 16'h0000);
      send_beat(ACT_SAMPLE, 16'h1234);
      send_beat(ACT_FLUSH, 16'h0000);
      send_beat(ACT_SAMPLE, 16'h7FFF);
      // next frame back to back, all at the positive limit
      for (int i = 0; i < 9; i++) send_beat(ACT_SAMPLE, 16'h7FFF);
      for (int i = 0; i < 4; i++) send_beat(ACT_FLUSH, 16'hFFFF);
   endtask

   task automatic test_size_clamps();
      configure_frame(16'h0000, 16'h0002);
      for (int i = 0; i < 9; i++) send_beat(ACT_SAMPLE, 16'h8000);
      for (int i = 0; i < 4; i++) send_beat(ACT_FLUSH, 16'h0000);
   endtask

   task automatic test_spare_index_and_restart();
      configure_frame(16'd4, 16'd4);
      send_frame(6, 1'b0);
      write_reg(CSR_SPARE, 16'hFFFF);   // no such register, frame carries on
      send_frame(10, 1'b1);
      send_frame(5, 1'b0);
      write_reg(CSR_FRAME_HEIGHT, 16'd4);
      send_frame(16, 1'b1);
   endtask

   task automatic test_tallest_frame();
      configure_frame(16'd3, 16'hFFFF);
      send_frame(90, 1'b0);
   endtask

   task automatic test_widest_frame();
      // width clamps to the line store depth; a short stretch of the first row
      configure_frame(16'h07FF, 16'h0000);
      send_frame(WIDE_BEATS, 1'b0);
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure_frame(16'd10, 16'd8);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_frame(80, 1'b1);
      join
   endtask

   task automatic test_random_frames(input int send_pct, input int recv_pct);
      int unsigned start, w, roll;
      bit          need_config;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start       = beats_sent;
      need_config = 1'b1;
      while (beats_sent - start < RANDOM_BEATS) begin
         if (need_config || $urandom_range(3) == 0) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            configure_frame(CSR_W'({$urandom, FW_W'(w)}), CSR_W'($urandom_range(3, 7)));
         end
         roll = $urandom_range(99);
         if (roll < 80) begin
            send_frame(frame_w * frame_h, 1'b1);
            need_config = 1'b0;
         end else if (roll < 92) begin
            // cut short; the next size write restarts the frame
            send_frame($urandom_range(1, frame_w * frame_h - 1), 1'b0);
            need_config = 1'b1;
         end else begin
            send_frame(frame_w * frame_h, 1'b1);
            repeat ($urandom_range(1, 3)) send_beat(ACT_FLUSH, SAMPLE_W'($urandom));
            need_config = 1'b0;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int k = 0; k < 9; k++) win[k] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = FW_W'(RESET_DIM);
      height_reg = ROW_W'(RESET_DIM);
      frame_w    = frame_cols();
      frame_h    = frame_rows();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_default_size();
      test_edge_values();
      test_size_clamps();
      test_spare_index_and_restart();
      test_tallest_frame();
      test_widest_frame();
      test_backpressure();
      test_random_frames(0, 0);
      test_random_frames(88, 0);
      test_random_frames(0, 88);
      test_random_frames(29, 29);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      settle_block();
      $display("run: %0d beats, frames from 3x3 to 1024 wide and 65535 tall, %0d size writes",
               beats_sent, csr_writes);
      $display("run: %0d filtered samples compared, %0d mismatches",
               results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results still due", pending_out.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
